// File: hdl/quaternion_multiply_rotate_unit_macros.svh
// ----------------------------------------------------------------------------
// Quaternion multiply / rotate unit assertion macros
// Shared concurrent assertion templates for the quaternion datapath.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_MULTIPLY_ROTATE_UNIT_MACROS_SVH
`define QUATERNION_MULTIPLY_ROTATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QMRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("quaternion unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QMRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("quaternion unit: next-cycle check failed");

`endif

// File: hdl/qmru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion multiply / rotate unit package
// Defaults, operation codes and the term routing tables of the datapath.
// ----------------------------------------------------------------------------
package qmru_pkg;

    localparam int unsigned DATA_WIDTH_DEF = 24;
    localparam int unsigned FRAC_BITS_DEF  = 16;

    localparam int unsigned NUM_PARTS  = 4;
    localparam int unsigned NUM_TERMS  = 8;
    localparam int unsigned OP0_TERMS  = 4;
    localparam int unsigned NUM_SLOTS  = 16;
    localparam int unsigned NUM_STAGES = 7;
    localparam int unsigned PART_W     = 0;

    typedef enum logic {
        OP_PRODUCT = 1'b0,
        OP_ROTATE  = 1'b1
    } t_op;

    typedef logic [3:0] t_src;
    typedef logic [1:0] t_vec;

    // Pair products of A used by the rotation, in slot order:
    // ww, xx, yy, zz, wx, wy, wz, xy, xz, yz. The remaining slots are unused.
    localparam t_vec PAIR_L [NUM_SLOTS] = '{
        2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd0, 2'd1,
        2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
    };
    localparam t_vec PAIR_R [NUM_SLOTS] = '{
        2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2,
        2'd3, 2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
    };
    // Cross pairs carry a factor of two.
    localparam logic [NUM_SLOTS-1:0] DBL_MASK = 16'h03F0;

    // Hamilton product: slot 4*i+j holds a_i*b_j.
    localparam t_src P0_SRC [NUM_PARTS][NUM_TERMS] = '{
        '{4'd0, 4'd5, 4'd10, 4'd15, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd1, 4'd4, 4'd11, 4'd14, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd2, 4'd7, 4'd8,  4'd13, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd3, 4'd6, 4'd9,  4'd12, 4'd0, 4'd0, 4'd0, 4'd0}
    };
    localparam logic [NUM_TERMS-1:0] P0_NEG [NUM_PARTS] = '{
        8'b0000_1110, 8'b0000_1000, 8'b0000_0010, 8'b0000_0100
    };

    // Rotation: pair slot times vector component of B.
    localparam t_src P1_SRC [NUM_PARTS][NUM_TERMS] = '{
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd5, 4'd6, 4'd1, 4'd7, 4'd8, 4'd3, 4'd2},
        '{4'd7, 4'd2, 4'd9, 4'd6, 4'd3, 4'd0, 4'd4, 4'd1},
        '{4'd8, 4'd9, 4'd3, 4'd5, 4'd2, 4'd4, 4'd1, 4'd0}
    };
    localparam t_vec P1_VEC [NUM_PARTS][NUM_TERMS] = '{
        '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd1, 2'd3, 2'd2, 2'd1, 2'd2, 2'd3, 2'd1, 2'd1},
        '{2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd2},
        '{2'd1, 2'd2, 2'd3, 2'd1, 2'd3, 2'd2, 2'd3, 2'd3}
    };
    localparam logic [NUM_TERMS-1:0] P1_NEG [NUM_PARTS] = '{
        8'b0000_0000, 8'b1100_0100, 8'b1101_0000, 8'b0101_1000
    };

endpackage

// File: hdl/quaternion_multiply_rotate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion multiply / rotate unit
// Hamilton product of two quaternions, or rotation of a vector by a
// quaternion, in signed saturating fixed point.
// ----------------------------------------------------------------------------
//  Channel   Dir  tdata (low bit up)                       tuser
//  s_axis    in   a_w a_x a_y a_z b_w b_x b_y b_z          req_type
//  m_axis    out  res_w res_x res_y res_z                  none
//
//  One transfer is accepted per cycle unless a stalled output has filled the
//  pipeline, which is made of the input register, two multiply stages, two
//  saturation stages, a partial sum and the final sum, which is held in the
//  output register. A stalled output holds its stage, and each earlier stage
//  advances whenever the stage after it is empty or moving, so bubbles are
//  squeezed out. Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
`include "quaternion_multiply_rotate_unit_macros.svh"

module quaternion_multiply_rotate_unit #(
    parameter int unsigned DATA_WIDTH = qmru_pkg::DATA_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = qmru_pkg::FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    input  logic [((8*DATA_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    // req_type
    input  logic                                      s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // res_w, res_x, res_y, res_z
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]         m_axis_tdata
);

    localparam int unsigned DW = DATA_WIDTH;
    localparam int unsigned FB = FRAC_BITS;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned HW = DW + 2;
    localparam int unsigned SW = DW + 3;
    localparam int unsigned NP = qmru_pkg::NUM_PARTS;
    localparam int unsigned NT = qmru_pkg::NUM_TERMS;
    localparam int unsigned NK = qmru_pkg::NUM_SLOTS;
    localparam int unsigned NS = qmru_pkg::NUM_STAGES;
    localparam int unsigned HT = NT / 2;

    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    function automatic logic signed [DW-1:0] f_sat_prod(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        logic signed [DW-1:0] r;
        s = p >>> FB;
        if ((&s[PW-1:DW-1]) || !(|s[PW-1:DW-1])) begin
            r = s[DW-1:0];
        end else begin
            r = s[PW-1] ? SMIN : SMAX;
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] f_dbl(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] r;
        if (v[DW-1] == v[DW-2]) begin
            r = {v[DW-2:0], 1'b0};
        end else begin
            r = v[DW-1] ? SMIN : SMAX;
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] f_sat_sum(input logic signed [SW-1:0] v);
        logic signed [DW-1:0] r;
        if ((&v[SW-1:DW-1]) || !(|v[SW-1:DW-1])) begin
            r = v[DW-1:0];
        end else begin
            r = v[SW-1] ? SMIN : SMAX;
        end
        return r;
    endfunction

    logic [NS:1] r_v;
    logic [NS:1] en;

    qmru_pkg::t_op r1_op, r2_op, r3_op, r4_op, r5_op, r6_op, r7_op;

    logic signed [DW-1:0] r1_a [NP];
    logic signed [DW-1:0] r1_b [NP];
    logic signed [DW-1:0] r2_b [NP];
    logic signed [DW-1:0] r3_b [NP];
    logic signed [PW-1:0] r2_p [NK];
    logic signed [PW-1:0] n2_p [NK];
    logic signed [DW-1:0] r3_f [NK];
    logic signed [DW-1:0] n3_f [NK];
    logic signed [PW-1:0] r4_p [NP][NT];
    logic signed [PW-1:0] n4_p [NP][NT];
    logic signed [DW-1:0] r5_s [NP][NT];
    logic signed [DW-1:0] n5_s [NP][NT];
    logic signed [HW-1:0] r6_h [NP][2];
    logic signed [HW-1:0] n6_h [NP][2];
    logic signed [DW-1:0] r7_res [NP];
    logic signed [DW-1:0] n7_res [NP];

    always_comb begin
        en[NS] = !r_v[NS] || m_axis_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[1];
    assign m_axis_tvalid = r_v[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = NS; k >= 2; k--) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (en[1]) begin
                r_v[1] <= s_axis_tvalid;
            end
        end
    end

    always_comb begin
        logic [3:0]           kk;
        logic signed [DW-1:0] ml;
        logic signed [DW-1:0] mr;
        for (int k = 0; k < NK; k++) begin
            kk = 4'(k);
            if (r1_op == qmru_pkg::OP_ROTATE) begin
                ml = r1_a[qmru_pkg::PAIR_L[k]];
                mr = r1_a[qmru_pkg::PAIR_R[k]];
            end else begin
                ml = r1_a[kk[3:2]];
                mr = r1_b[kk[1:0]];
            end
            n2_p[k] = PW'(ml) * PW'(mr);
        end
    end

    always_comb begin
        for (int k = 0; k < NK; k++) begin
            n3_f[k] = f_sat_prod(r2_p[k]);
            if (r2_op == qmru_pkg::OP_ROTATE && qmru_pkg::DBL_MASK[k]) begin
                n3_f[k] = f_dbl(f_sat_prod(r2_p[k]));
            end
        end
    end

    always_comb begin
        for (int o = 0; o < NP; o++) begin
            for (int t = 0; t < NT; t++) begin
                n4_p[o][t] = '0;
                if (r3_op == qmru_pkg::OP_ROTATE) begin
                    if (o != qmru_pkg::PART_W) begin
                        n4_p[o][t] = PW'(r3_f[qmru_pkg::P1_SRC[o][t]])
                                   * PW'(r3_b[qmru_pkg::P1_VEC[o][t]]);
                    end
                end else if (t < qmru_pkg::OP0_TERMS) begin
                    n4_p[o][t] = PW'(r3_f[qmru_pkg::P0_SRC[o][t]]);
                end
            end
        end
    end

    always_comb begin
        for (int o = 0; o < NP; o++) begin
            for (int t = 0; t < NT; t++) begin
                if (r4_op == qmru_pkg::OP_ROTATE) begin
                    n5_s[o][t] = f_sat_prod(r4_p[o][t]);
                end else begin
                    n5_s[o][t] = r4_p[o][t][DW-1:0];
                end
            end
        end
    end

    always_comb begin
        logic [NT-1:0]        neg;
        logic signed [HW-1:0] acc;
        logic signed [HW-1:0] term;
        for (int o = 0; o < NP; o++) begin
            neg = (r5_op == qmru_pkg::OP_ROTATE) ? qmru_pkg::P1_NEG[o] : qmru_pkg::P0_NEG[o];
            for (int h = 0; h < 2; h++) begin
                acc = '0;
                for (int t = 0; t < HT; t++) begin
                    term = HW'(r5_s[o][h*HT+t]);
                    acc  = neg[h*HT+t] ? (acc - term) : (acc + term);
                end
                n6_h[o][h] = acc;
            end
        end
    end

    always_comb begin
        for (int o = 0; o < NP; o++) begin
            n7_res[o] = f_sat_sum(SW'(r6_h[o][0]) + SW'(r6_h[o][1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_op <= qmru_pkg::t_op'(s_axis_tuser);
            for (int c = 0; c < NP; c++) begin
                r1_a[c] <= s_axis_tdata[c*DW +: DW];
                r1_b[c] <= s_axis_tdata[(NP+c)*DW +: DW];
            end
        end
        if (en[2]) begin
            r2_op <= r1_op;
            r2_b  <= r1_b;
            r2_p  <= n2_p;
        end
        if (en[3]) begin
            r3_op <= r2_op;
            r3_b  <= r2_b;
            r3_f  <= n3_f;
        end
        if (en[4]) begin
            r4_op <= r3_op;
            r4_p  <= n4_p;
        end
        if (en[5]) begin
            r5_op <= r4_op;
            r5_s  <= n5_s;
        end
        if (en[6]) begin
            r6_op <= r5_op;
            r6_h  <= n6_h;
        end
        if (en[7]) begin
            r7_op  <= r6_op;
            r7_res <= n7_res;
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        for (int c = 0; c < NP; c++) begin
            m_axis_tdata[c*DW +: DW] = r7_res[c];
        end
    end

    `QMRU_ASSERT_NOW(a_ready_only_blocked_by_output, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
    `QMRU_ASSERT_NOW(a_rotate_scalar_zero, i_clk, i_rst_n, m_axis_tvalid && r7_op == qmru_pkg::OP_ROTATE, r7_res[0] == '0)
    `QMRU_ASSERT_NEXT(a_sum_stage_holds, i_clk, i_rst_n, r_v[7] && r_v[6] && !m_axis_tready, r_v[6] && $stable(r6_op) && $stable(r6_h[1][0]))
    `QMRU_ASSERT_NEXT(a_accept_enters_pipe, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_v[1])

endmodule

// File: dv/tb_quaternion_multiply_rotate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion multiply / rotate unit testbench
// Sends Hamilton products and vector rotations through the streaming ports
// while both sides idle at random, including one long output stall, and
// checks every result against a fixed-point model of the saturating datapath.
// ----------------------------------------------------------------------------
module tb_quaternion_multiply_rotate_unit;

    localparam int unsigned DW = qmru_pkg::DATA_WIDTH_DEF;
    localparam int unsigned FB = qmru_pkg::FRAC_BITS_DEF;
    localparam longint FX_MAX = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint FX_MIN = -FX_MAX - 1;
    localparam logic [DW-1:0] ONE = DW'(longint'(1) <<< FB);
    localparam logic [DW-1:0] VMAX = DW'(FX_MAX);
    localparam logic [DW-1:0] VMIN = DW'(FX_MIN);
    localparam int RUN_ITEMS = 330;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic [3:0][DW-1:0] t_quat;

    typedef struct packed {
        qmru_pkg::t_op op;
        t_quat         b;
        t_quat         a;
    } t_quat_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [8*DW-1:0]       s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [4*DW-1:0]       m_axis_tdata;

    t_quat_req pending_reqs[$];
    t_quat     expected_quats[$];
    int        src_idle_pct = 0;
    int        sink_stall_pct = 0;
    bit        hold_request = 1'b0;
    bit        rx_hold = 1'b0;
    int        fail_count = 0;
    int        cycle_count = 0;

    quaternion_multiply_rotate_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic longint fx_clamp(longint v);
        if (v > FX_MAX) begin
            return FX_MAX;
        end
        if (v < FX_MIN) begin
            return FX_MIN;
        end
        return v;
    endfunction

    // The arithmetic shift drops the low bits, which rounds toward minus infinity.
    function automatic longint fx_mul(longint l, longint r);
        longint p;
        p = l * r;
        return fx_clamp(p >>> FB);
    endfunction

    function automatic longint fx_dbl(longint v);
        return fx_clamp(2 * v);
    endfunction

    function automatic t_quat quat_result(qmru_pkg::t_op op, t_quat qa, t_quat qb);
        longint aw, ax, ay, az, bw, bx, by, bz;
        longint ww, xx, yy, zz, wx2, wy2, wz2, xy2, xz2, yz2;
        longint rw, rx, ry, rz;
        t_quat  res;
        aw = signed'(qa[0]);
        ax = signed'(qa[1]);
        ay = signed'(qa[2]);
        az = signed'(qa[3]);
        bw = signed'(qb[0]);
        bx = signed'(qb[1]);
        by = signed'(qb[2]);
        bz = signed'(qb[3]);
        if (op == qmru_pkg::OP_PRODUCT) begin
            rw = fx_mul(aw, bw) - fx_mul(ax, bx) - fx_mul(ay, by) - fx_mul(az, bz);
            rx = fx_mul(aw, bx) + fx_mul(ax, bw) + fx_mul(ay, bz) - fx_mul(az, by);
            ry = fx_mul(aw, by) - fx_mul(ax, bz) + fx_mul(ay, bw) + fx_mul(az, bx);
            rz = fx_mul(aw, bz) + fx_mul(ax, by) - fx_mul(ay, bx) + fx_mul(az, bw);
        end else begin
            ww  = fx_mul(aw, aw);
            xx  = fx_mul(ax, ax);
            yy  = fx_mul(ay, ay);
            zz  = fx_mul(az, az);
            wx2 = fx_dbl(fx_mul(aw, ax));
            wy2 = fx_dbl(fx_mul(aw, ay));
            wz2 = fx_dbl(fx_mul(aw, az));
            xy2 = fx_dbl(fx_mul(ax, ay));
            xz2 = fx_dbl(fx_mul(ax, az));
            yz2 = fx_dbl(fx_mul(ay, az));
            rw = 0;
            rx = fx_mul(ww, bx) + fx_mul(wy2, bz) - fx_mul(wz2, by) + fx_mul(xx, bx)
               + fx_mul(xy2, by) + fx_mul(xz2, bz) - fx_mul(zz, bx) - fx_mul(yy, bx);
            ry = fx_mul(xy2, bx) + fx_mul(yy, by) + fx_mul(yz2, bz) + fx_mul(wz2, bx)
               - fx_mul(zz, by) + fx_mul(ww, by) - fx_mul(wx2, bz) - fx_mul(xx, by);
            rz = fx_mul(xz2, bx) + fx_mul(yz2, by) + fx_mul(zz, bz) - fx_mul(wy2, bx)
               - fx_mul(yy, bz) + fx_mul(wx2, by) - fx_mul(xx, bz) + fx_mul(ww, bz);
        end
        rw = fx_clamp(rw);
        rx = fx_clamp(rx);
        ry = fx_clamp(ry);
        rz = fx_clamp(rz);
        res[0] = rw[DW-1:0];
        res[1] = rx[DW-1:0];
        res[2] = ry[DW-1:0];
        res[3] = rz[DW-1:0];
        return res;
    endfunction

    function automatic t_quat quat(logic [DW-1:0] w, logic [DW-1:0] x,
                                   logic [DW-1:0] y, logic [DW-1:0] z);
        return {z, y, x, w};
    endfunction

    function automatic t_quat full_quat();
        t_quat q;
        for (int k = 0; k < 4; k++) begin
            q[k] = DW'($urandom());
        end
        return q;
    endfunction

    // Values within a few units keep most sums clear of the saturation limits.
    function automatic t_quat near_quat();
        t_quat q;
        int    span;
        span = 1 << (FB + $urandom_range(0, 3));
        for (int k = 0; k < 4; k++) begin
            q[k] = DW'(int'($urandom_range(0, 2 * span)) - span);
        end
        return q;
    endfunction

    function automatic t_quat unit_quat();
        real   c[4];
        real   norm;
        t_quat q;
        norm = 0.0;
        for (int k = 0; k < 4; k++) begin
            c[k] = real'(int'($urandom_range(0, 2000)) - 1000);
            norm = norm + c[k] * c[k];
        end
        if (norm < 1.0) begin
            c[0] = 1.0;
            norm = 1.0;
        end
        norm = $sqrt(norm);
        for (int k = 0; k < 4; k++) begin
            q[k] = DW'(int'(c[k] / norm * real'(ONE)));
        end
        return q;
    endfunction

    task automatic push_req(qmru_pkg::t_op op, t_quat qa, t_quat qb);
        t_quat_req r;
        r.op = op;
        r.a = qa;
        r.b = qb;
        pending_reqs.push_back(r);
    endtask

    task automatic push_random(int count);
        int            mode;
        qmru_pkg::t_op op;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 9);
            op = qmru_pkg::t_op'($urandom_range(0, 1));
            if (mode < 4) begin
                push_req(op, near_quat(), near_quat());
            end else if (mode < 7) begin
                push_req(op, unit_quat(), near_quat());
            end else begin
                push_req(op, full_quat(), full_quat());
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_quats.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR: %s at %0t ns", msg, $time);
        fail_count++;
    endtask

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_quat_req next_req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                next_req = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {next_req.b, next_req.a};
                s_axis_tuser <= next_req.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_quat want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_quats.push_back(quat_result(qmru_pkg::t_op'(s_axis_tuser),
                    s_axis_tdata[4*DW-1:0], s_axis_tdata[8*DW-1:4*DW]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_quats.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer %h", m_axis_tdata));
                end else begin
                    want = expected_quats.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (m_axis_tdata[k*DW +: DW] !== want[k]) begin
                            report_mismatch($sformatf("part %0d got %h expected %h",
                                k, m_axis_tdata[k*DW +: DW], want[k]));
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // The long output stall is timed here so the sender keeps offering meanwhile.
    initial begin
        wait (hold_request);
        @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (300) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        int src_pct[4];
        int sink_pct[4];
        src_pct = '{0, 64, 0, 17};
        sink_pct = '{0, 0, 64, 17};

        push_req(qmru_pkg::OP_PRODUCT, '0, '0);
        push_req(qmru_pkg::OP_PRODUCT, quat(ONE, '0, '0, '0),
                 quat(ONE + (ONE >> 1), DW'(-2 * ONE), DW'(3 * ONE), -(ONE >> 2)));
        push_req(qmru_pkg::OP_PRODUCT, {4{VMAX}}, {4{VMAX}});
        push_req(qmru_pkg::OP_PRODUCT, {4{VMIN}}, {4{VMIN}});
        push_req(qmru_pkg::OP_PRODUCT, {4{VMAX}}, {4{VMIN}});
        push_req(qmru_pkg::OP_PRODUCT, quat(VMIN, VMAX, VMIN, VMAX),
                 quat(VMAX, VMIN, VMAX, VMIN));
        push_req(qmru_pkg::OP_PRODUCT, {4{DW'(-1)}}, quat(DW'(1), DW'(1), DW'(-1), DW'(1)));
        push_req(qmru_pkg::OP_PRODUCT, {4{24'hAAAAAA}}, {4{24'h555555}});
        push_req(qmru_pkg::OP_ROTATE, quat(ONE, '0, '0, '0),
                 quat(VMAX, DW'(2 * ONE), DW'(-3 * ONE), ONE >> 1));
        push_req(qmru_pkg::OP_ROTATE, quat(DW'(46341), '0, '0, DW'(46341)),
                 quat('0, ONE, '0, '0));
        push_req(qmru_pkg::OP_ROTATE, quat('0, ONE, '0, '0),
                 quat('0, ONE, DW'(2 * ONE), DW'(3 * ONE)));
        push_req(qmru_pkg::OP_ROTATE, quat(DW'(2 * ONE), '0, '0, '0),
                 quat('0, ONE, -ONE, ONE >> 1));
        push_req(qmru_pkg::OP_ROTATE, {4{VMAX}}, {4{VMAX}});
        push_req(qmru_pkg::OP_ROTATE, {4{VMIN}}, {4{VMIN}});
        push_req(qmru_pkg::OP_ROTATE, quat(VMIN, VMAX, VMIN, VMAX),
                 quat(VMAX, VMIN, VMAX, VMIN));
        push_req(qmru_pkg::OP_ROTATE, {4{24'h555555}}, {4{24'hAAAAAA}});
        push_req(qmru_pkg::OP_ROTATE, '0, {4{VMAX}});
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            src_idle_pct = src_pct[p];
            sink_stall_pct = sink_pct[p];
            push_random(RUN_ITEMS);
            wait_drained();
        end

        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_request = 1'b1;
        push_random(120);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (expected_quats.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_quats.size()));
        end
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
